/* rtl/ordered_dither_binarizer_defines.svh */
// ----------------------------------------------------------------------------
// ordered_dither_binarizer_defines.svh
// Assertion macros shared by the binarizer checkers.
// ----------------------------------------------------------------------------
`ifndef ORDERED_DITHER_BINARIZER_DEFINES_SVH
`define ORDERED_DITHER_BINARIZER_DEFINES_SVH

// Implication checked on the same edge, masked while reset is high.
`define ODB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked on the following edge, masked while reset is high.
`define ODB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Following-edge check that also covers the reset cycles.
`define ODB_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/odb_pkg.sv */
// ----------------------------------------------------------------------------
// odb_pkg
// Types, register indexes and dither tables for the ordered dither binarizer.
// ----------------------------------------------------------------------------
package odb_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_MASK_SIZE   = 2'd0;
   localparam logic [1:0] CSR_MAX_GRAY    = 2'd1;
   localparam logic [1:0] CSR_IMAGE_WIDTH = 2'd2;

   localparam int GRAY_BITS  = 16;
   localparam int WIDTH_REG_BITS = 12;
   localparam int THR_BITS   = 4;
   localparam int LIMIT_BITS = GRAY_BITS + THR_BITS + 1;

   // matrix orders
   localparam logic [2:0] ORDER_2 = 3'd2;
   localparam logic [2:0] ORDER_3 = 3'd3;
   localparam logic [2:0] ORDER_4 = 3'd4;

   // row-major, index {row, col}
   localparam logic [THR_BITS-1:0] DITHER_TAB2 [16] = '{
      4'd0, 4'd2, 4'd0, 4'd0,
      4'd3, 4'd1, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd0 };
   localparam logic [THR_BITS-1:0] DITHER_TAB3 [16] = '{
      4'd2, 4'd6, 4'd4, 4'd0,
      4'd5, 4'd0, 4'd1, 4'd0,
      4'd8, 4'd3, 4'd7, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd0 };
   localparam logic [THR_BITS-1:0] DITHER_TAB4 [16] = '{
      4'd0,  4'd8,  4'd2,  4'd10,
      4'd12, 4'd4,  4'd14, 4'd6,
      4'd3,  4'd11, 4'd1,  4'd9,
      4'd15, 4'd7,  4'd13, 4'd5 };

   // configuration as seen by the datapath
   typedef struct packed {
      logic [2:0]                k;      // clamped order, 2..4
      logic [GRAY_BITS-1:0]      step;   // max_gray / (k*k-1), at least 1
      logic [WIDTH_REG_BITS-1:0] width;  // pixels per row
   } cfg_type;

   // matrix position of one pixel
   typedef struct packed {
      logic [1:0] row;
      logic [1:0] col;
   } pos_type;

   function automatic logic [THR_BITS-1:0] dither_thr(input logic [2:0] k,
                                                      input pos_type   pos);
      logic [3:0] idx;
      idx = {pos.row, pos.col};
      case (k)
         ORDER_2: dither_thr = DITHER_TAB2[idx];
         ORDER_3: dither_thr = DITHER_TAB3[idx];
         default: dither_thr = DITHER_TAB4[idx];
      endcase
   endfunction

   function automatic logic [1:0] phase_next(input logic [1:0] p,
                                             input logic [2:0] k);
      logic [2:0] p1;
      p1 = {1'b0, p} + 3'd1;
      phase_next = (p1 >= k) ? 2'd0 : p1[1:0];
   endfunction

endpackage

/* rtl/odb_csr.sv */
// ----------------------------------------------------------------------------
// odb_csr
// Configuration registers; keeps the clamped order and the derived step.
// ----------------------------------------------------------------------------
module odb_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [odb_pkg::GRAY_BITS-1:0] csr_wdata,
   output odb_pkg::cfg_type              cfg
);

   logic [2:0]                            k_ff, k_in;
   logic [odb_pkg::GRAY_BITS-1:0]         max_gray_ff, max_gray_in;
   logic [odb_pkg::WIDTH_REG_BITS-1:0]    width_ff, width_in;
   logic [odb_pkg::GRAY_BITS-1:0]         step_ff, step_in;
   logic [2:0]                            mask_wr;
   logic [15:0]                           recip;
   logic [4:0]                            shift;
   logic [31:0]                           prod;
   logic [odb_pkg::GRAY_BITS-1:0]         quo;

   assign csr_ready = 1'b1;
   assign mask_wr   = csr_wdata[2:0];

   always_comb begin
      k_in        = k_ff;
      max_gray_in = max_gray_ff;
      width_in    = width_ff;
      if (csr_valid) begin
         unique case (csr_index)
            odb_pkg::CSR_MASK_SIZE: begin
               if (mask_wr < odb_pkg::ORDER_2)
                  k_in = odb_pkg::ORDER_2;
               else if (mask_wr > odb_pkg::ORDER_4)
                  k_in = odb_pkg::ORDER_4;
               else
                  k_in = mask_wr;
            end
            odb_pkg::CSR_MAX_GRAY:    max_gray_in = csr_wdata;
            odb_pkg::CSR_IMAGE_WIDTH: width_in = csr_wdata[odb_pkg::WIDTH_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // divide by 3, 8 or 15 as a reciprocal multiply (exact for 16-bit values)
   always_comb begin
      case (k_in)
         odb_pkg::ORDER_2: begin
            recip = 16'hAAAB;
            shift = 5'd17;
         end
         odb_pkg::ORDER_3: begin
            recip = 16'd1;
            shift = 5'd3;
         end
         default: begin
            recip = 16'h8889;
            shift = 5'd19;
         end
      endcase
      prod    = 32'(max_gray_in) * 32'(recip);
      quo     = odb_pkg::GRAY_BITS'(prod >> shift);
      step_in = (quo == '0) ? odb_pkg::GRAY_BITS'(1) : quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff        <= odb_pkg::ORDER_4;
         max_gray_ff <= 16'd255;
         width_ff    <= 12'd640;
         step_ff     <= 16'd17;
      end else begin
         k_ff        <= k_in;
         max_gray_ff <= max_gray_in;
         width_ff    <= width_in;
         step_ff     <= step_in;
      end
   end

   assign cfg.k     = k_ff;
   assign cfg.step  = step_ff;
   assign cfg.width = width_ff;

endmodule

/* rtl/odb_raster.sv */
// ----------------------------------------------------------------------------
// odb_raster
// Column counter and row/column phase tracking over the raster scan.
// ----------------------------------------------------------------------------
module odb_raster #(
   parameter int WIDTH_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             start_of_image,
   input  odb_pkg::cfg_type cfg,
   output odb_pkg::pos_type pos
);

   logic [WIDTH_BITS-1:0] col_count_ff, col_count_in;
   logic [1:0]            col_phase_ff, col_phase_in;
   logic [1:0]            row_phase_ff, row_phase_in;
   logic [WIDTH_BITS-1:0] count_cur, count_inc, width_wrap;
   logic [1:0]            col_cur, row_cur;
   logic                  row_end;

   // start of image clears position before the pixel is looked up
   assign count_cur  = start_of_image ? '0 : col_count_ff;
   assign col_cur    = start_of_image ? 2'd0 : col_phase_ff;
   assign row_cur    = start_of_image ? 2'd0 : row_phase_ff;
   assign count_inc  = count_cur + WIDTH_BITS'(1);
   assign width_wrap = WIDTH_BITS'({4'd0, cfg.width});
   assign row_end    = (count_inc == width_wrap);

   // stale phase after an order change reads entry 0
   assign pos.row = ({1'b0, row_cur} < cfg.k) ? row_cur : 2'd0;
   assign pos.col = ({1'b0, col_cur} < cfg.k) ? col_cur : 2'd0;

   always_comb begin
      col_count_in = col_count_ff;
      col_phase_in = col_phase_ff;
      row_phase_in = row_phase_ff;
      if (advance) begin
         if (row_end) begin
            col_count_in = '0;
            col_phase_in = 2'd0;
            row_phase_in = odb_pkg::phase_next(row_cur, cfg.k);
         end else begin
            col_count_in = count_inc;
            col_phase_in = odb_pkg::phase_next(col_cur, cfg.k);
            row_phase_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         col_phase_ff <= 2'd0;
         row_phase_ff <= 2'd0;
      end else begin
         col_count_ff <= col_count_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
      end
   end

endmodule

/* rtl/ordered_dither_binarizer.sv */
// ----------------------------------------------------------------------------
// ordered_dither_binarizer
// Ordered (Bayer) dithering of a raster gray stream to one bit per pixel.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one gray pixel per beat in raster order; req_start_of_image
//    flags the first pixel of an image and clears position and white flag.
//  - rsp_ channel: one beat per pixel, rsp_bw (1 = white) and rsp_any_white,
//    the sticky flag over the image so far including this pixel.
//  - csr_ channel: register writes (0 mask_size, 1 max_gray, 2 image_width),
//    always ready; write only while no pixel is in flight.
// Timing:
//  - Two register stages: input stage, then result register. An accepted
//    req beat is loaded into the input stage, then into the result register
//    when that is empty or being drained; rsp_valid rises as it loads.
//  - Throughput is one pixel per cycle while rsp_ready stays high; the
//    compare and threshold multiply sit between the two stages.
//  - The divide of max_gray by k*k-1 is done at the register write and kept
//    in a step register, so the pixel path only multiplies and compares.
// Reset: synchronous, active high; empties both stages, restores the
//    register defaults (k=4, max_gray=255, width=640), clears the position.
// Stall: while rsp_ready is low the result holds; one more pixel is taken
//    into the input stage, after which req_ready drops.
// ----------------------------------------------------------------------------
module ordered_dither_binarizer #(
   parameter int WIDTH_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   // pixel input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [odb_pkg::GRAY_BITS-1:0] req_gray,
   input  logic                          req_start_of_image,
   // result output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_bw,
   output logic                          rsp_any_white,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [odb_pkg::GRAY_BITS-1:0] csr_wdata
);

   odb_pkg::cfg_type cfg;
   odb_pkg::pos_type pos;

   logic accept;
   logic out_load;

   // input stage
   logic                          s1_valid_ff, s1_valid_in;
   logic [odb_pkg::GRAY_BITS-1:0] s1_gray_ff;
   logic                          s1_sof_ff;
   odb_pkg::pos_type              s1_pos_ff;

   // result stage
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_bw_ff;
   logic any_white_ff, any_white_in;

   logic [odb_pkg::THR_BITS-1:0]   thr;
   logic [odb_pkg::LIMIT_BITS-1:0] limit;
   logic                           bw;

   odb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // position advances at acceptance, so each pixel carries its own phase
   odb_raster #(
      .WIDTH_BITS (WIDTH_BITS)
   ) u_raster (
      .clock          (clock),
      .reset          (reset),
      .advance        (accept),
      .start_of_image (req_start_of_image),
      .cfg            (cfg),
      .pos            (pos)
   );

   // handshake: result register loads when empty or being drained
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_load;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept)
         s1_valid_in = 1'b1;
      else if (out_load)
         s1_valid_in = 1'b0;
      else
         s1_valid_in = s1_valid_ff;
      rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;
   end

   // floor(gray/step) > thr  <=>  gray >= (thr+1)*step
   assign thr   = odb_pkg::dither_thr(cfg.k, s1_pos_ff);
   assign limit = odb_pkg::LIMIT_BITS'(({1'b0, thr} + 5'd1) * cfg.step);
   assign bw    = ({{(odb_pkg::LIMIT_BITS-odb_pkg::GRAY_BITS){1'b0}}, s1_gray_ff} >= limit);

   // sticky flag restarts on the first pixel of an image
   assign any_white_in = (s1_sof_ff ? 1'b0 : any_white_ff) | bw;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         any_white_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (out_load && s1_valid_ff) begin
            any_white_ff <= any_white_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_gray_ff <= req_gray;
         s1_sof_ff  <= req_start_of_image;
         s1_pos_ff  <= pos;
      end
      if (out_load && s1_valid_ff) begin
         rsp_bw_ff <= bw;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bw        = rsp_bw_ff;
   assign rsp_any_white = any_white_ff;

endmodule

/* rtl/odb_checker.sv */
// ----------------------------------------------------------------------------
// odb_checker
// Port-level checks for the ordered dither binarizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_dither_binarizer_defines.svh"

module odb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_bw,
   input logic rsp_any_white,
   input logic csr_ready
);

   // stalled result holds
   `ODB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bw) && $stable(rsp_any_white), "rsp changed while stalled")

   // a white pixel always shows in the sticky flag
   `ODB_ASSERT_NOW(a_white_sticky, clock, reset, rsp_valid && rsp_bw, rsp_any_white, "white pixel without any_white")

   // a fresh result follows its pixel through the input stage with no stall between
   `ODB_ASSERT_NOW(a_latency, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without matching request")

   // reset empties the pipeline and opens both input ports
   `ODB_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid && req_ready && csr_ready, "pipeline not empty after reset")

endmodule

bind ordered_dither_binarizer odb_checker u_odb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_bw        (rsp_bw),
   .rsp_any_white (rsp_any_white),
   .csr_ready     (csr_ready)
);
